// ===== hdl/lisp_lex_pkg.sv =====
`default_nettype none
package lisp_lex_pkg;

    localparam logic [3:0] K_COMMENT = 4'd0;
    localparam logic [3:0] K_SPACE   = 4'd1;
    localparam logic [3:0] K_NUMBER  = 4'd2;
    localparam logic [3:0] K_SYMBOL  = 4'd3;
    localparam logic [3:0] K_STRING  = 4'd4;
    localparam logic [3:0] K_LPAREN  = 4'd5;
    localparam logic [3:0] K_RPAREN  = 4'd6;
    localparam logic [3:0] K_LBRACK  = 4'd7;
    localparam logic [3:0] K_RBRACK  = 4'd8;
    localparam logic [3:0] K_INVALID = 4'd9;

    localparam logic [7:0] C_TAB    = 8'h09;
    localparam logic [7:0] C_LF     = 8'h0A;
    localparam logic [7:0] C_CR     = 8'h0D;
    localparam logic [7:0] C_SPACE  = 8'h20;
    localparam logic [7:0] C_QUOTE  = 8'h22;
    localparam logic [7:0] C_LPAREN = 8'h28;
    localparam logic [7:0] C_RPAREN = 8'h29;
    localparam logic [7:0] C_STAR   = 8'h2A;
    localparam logic [7:0] C_PLUS   = 8'h2B;
    localparam logic [7:0] C_COMMA  = 8'h2C;
    localparam logic [7:0] C_MINUS  = 8'h2D;
    localparam logic [7:0] C_SLASH  = 8'h2F;
    localparam logic [7:0] C_SEMI   = 8'h3B;
    localparam logic [7:0] C_LBRACK = 8'h5B;
    localparam logic [7:0] C_BSLASH = 8'h5C;
    localparam logic [7:0] C_RBRACK = 8'h5D;

    localparam logic [31:0] LINE_MAX = 32'hFFFF_FFFF;
    localparam int          RES_MAX  = 3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } t_in;

    typedef struct packed {
        logic [3:0]         token_kind;
        logic               is_text;
        logic [7:0]         text_byte;
        logic               token_done;
        logic signed [63:0] number_value;
        logic [31:0]        line_number;
        logic               last;
    } t_out;

endpackage
`default_nettype wire

// ===== hdl/lisp_token_lexer_unit.sv =====
// Latency: a result beat is offered the cycle after its input beat is taken.
// Throughput: one input beat per cycle while i_stall is low and each byte
// gives at most one result; more results stall input in the 3-entry buffer.
// Reset (synchronous, active low): lexer idle, number state cleared,
// line count and token start line set to 1, result buffer empty.
`default_nettype none
module lisp_token_lexer_unit
    import lisp_lex_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_in  i_data,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_out      o_data
);

    typedef enum logic [2:0] {
        M_IDLE,
        M_COMMENT,
        M_SIGN,
        M_NUMBER,
        M_SYMBOL,
        M_STRING,
        M_ESCAPE
    } t_mode;

    t_mode       r_mode, n_mode;
    logic [63:0] r_acc, n_acc;
    logic        r_neg, n_neg;
    logic [7:0]  r_psc, n_psc;
    logic [31:0] r_line, n_line;
    logic [31:0] r_tsl, n_tsl;
    logic [1:0]  r_cnt, n_cnt;
    t_out        r_buf [RES_MAX];
    t_out        res   [RES_MAX];

    logic        in_beat, out_beat;
    logic [7:0]  c;
    logic        line_inc;

    logic        st_put, st_inc, st_neg;
    t_out        st_res;
    t_mode       st_mode;
    logic [63:0] st_acc;
    logic [7:0]  st_psc;

    logic [63:0]        digit_val;
    logic [63:0]        acc_next;
    logic signed [63:0] num_val;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_sym(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
               b == C_STAR || b == C_PLUS || b == C_MINUS || b == C_SLASH;
    endfunction

    function automatic logic [7:0] unescape(input logic [7:0] b);
        logic [7:0] u;
        unique case (b)
            8'h6E:   u = C_LF;
            8'h74:   u = C_TAB;
            8'h72:   u = C_CR;
            8'h62:   u = 8'h08;
            8'h76:   u = 8'h0B;
            default: u = b;
        endcase
        return u;
    endfunction

    function automatic t_out mk(input logic [3:0] kind, input logic text,
                                input logic [7:0] b, input logic done,
                                input logic signed [63:0] value,
                                input logic [31:0] line);
        t_out r;
        r.token_kind   = kind;
        r.is_text      = text;
        r.text_byte    = b;
        r.token_done   = done;
        r.number_value = value;
        r.line_number  = line;
        r.last         = 1'b0;
        return r;
    endfunction

    assign c         = i_data.in_byte;
    assign digit_val = {60'd0, c[3:0]};
    assign acc_next  = (r_acc << 3) + (r_acc << 1) + digit_val;
    assign num_val   = r_neg ? $signed(64'd0 - r_acc) : $signed(r_acc);

    assign o_stall  = !((r_cnt == 2'd0) || ((r_cnt == 2'd1) && !i_stall));
    assign in_beat  = i_valid && !o_stall;
    assign o_valid  = (r_cnt != 2'd0);
    assign out_beat = o_valid && !i_stall;
    assign o_data   = r_buf[0];

    // token start for byte c
    always_comb begin
        st_put  = 1'b0;
        st_inc  = 1'b0;
        st_res  = mk(K_INVALID, 1'b0, 8'd0, 1'b1, 64'sd0, r_line);
        st_mode = M_IDLE;
        st_acc  = r_acc;
        st_neg  = r_neg;
        st_psc  = r_psc;
        priority if (c == C_SEMI) begin
            st_mode = M_COMMENT;
        end else if (c == C_SPACE || (c >= C_TAB && c <= C_CR) || c == C_COMMA) begin
            st_put = 1'b1;
            st_res = mk(K_SPACE, 1'b0, 8'd0, 1'b1, 64'sd0, r_line);
            st_inc = (c == C_LF);
        end else if (is_digit(c)) begin
            st_acc  = digit_val;
            st_neg  = 1'b0;
            st_mode = M_NUMBER;
        end else if (c == C_PLUS || c == C_MINUS) begin
            st_psc  = c;
            st_mode = M_SIGN;
        end else if (is_sym(c)) begin
            st_put  = 1'b1;
            st_res  = mk(K_SYMBOL, 1'b1, c, 1'b0, 64'sd0, r_line);
            st_mode = M_SYMBOL;
        end else if (c == C_QUOTE) begin
            st_mode = M_STRING;
        end else if (c == C_LPAREN) begin
            st_put = 1'b1;
            st_res = mk(K_LPAREN, 1'b0, 8'd0, 1'b1, 64'sd0, r_line);
        end else if (c == C_RPAREN) begin
            st_put = 1'b1;
            st_res = mk(K_RPAREN, 1'b0, 8'd0, 1'b1, 64'sd0, r_line);
        end else if (c == C_LBRACK) begin
            st_put = 1'b1;
            st_res = mk(K_LBRACK, 1'b0, 8'd0, 1'b1, 64'sd0, r_line);
        end else if (c == C_RBRACK) begin
            st_put = 1'b1;
            st_res = mk(K_RBRACK, 1'b0, 8'd0, 1'b1, 64'sd0, r_line);
        end else begin
            st_put = 1'b1;
        end
    end

    always_comb begin
        logic start;
        start    = 1'b0;
        line_inc = 1'b0;
        n_mode   = r_mode;
        n_acc    = r_acc;
        n_neg    = r_neg;
        n_psc    = r_psc;
        n_tsl    = r_tsl;
        n_cnt    = 2'd0;
        for (int i = 0; i < RES_MAX; i++) begin
            res[i] = mk(K_COMMENT, 1'b0, 8'd0, 1'b0, 64'sd0, r_tsl);
        end

        if (i_data.end_of_input) begin
            unique case (r_mode)
                M_COMMENT: begin
                    res[0]   = mk(K_COMMENT, 1'b0, 8'd0, 1'b1, 64'sd0, r_tsl);
                    n_cnt    = 2'd1;
                    line_inc = 1'b1;
                end
                M_SIGN: begin
                    res[0] = mk(K_SYMBOL, 1'b1, r_psc, 1'b0, 64'sd0, r_tsl);
                    res[1] = mk(K_SYMBOL, 1'b0, 8'd0, 1'b1, 64'sd0, r_tsl);
                    n_cnt  = 2'd2;
                end
                M_NUMBER: begin
                    res[0] = mk(K_NUMBER, 1'b0, 8'd0, 1'b1, num_val, r_tsl);
                    n_cnt  = 2'd1;
                end
                M_SYMBOL: begin
                    res[0] = mk(K_SYMBOL, 1'b0, 8'd0, 1'b1, 64'sd0, r_tsl);
                    n_cnt  = 2'd1;
                end
                M_STRING, M_ESCAPE: begin
                    res[0] = mk(K_STRING, 1'b0, 8'd0, 1'b1, 64'sd0, r_tsl);
                    n_cnt  = 2'd1;
                end
                default: ;
            endcase
            n_mode = M_IDLE;
            n_acc  = 64'd0;
            n_neg  = 1'b0;
            n_psc  = 8'd0;
        end else begin
            unique case (r_mode)
                M_COMMENT: begin
                    if (c == C_LF) begin
                        res[0]   = mk(K_COMMENT, 1'b0, 8'd0, 1'b1, 64'sd0, r_tsl);
                        n_cnt    = 2'd1;
                        line_inc = 1'b1;
                        n_mode   = M_IDLE;
                    end
                end
                M_SIGN: begin
                    if (is_digit(c)) begin
                        n_acc  = digit_val;
                        n_neg  = (r_psc == C_MINUS);
                        n_mode = M_NUMBER;
                    end else begin
                        res[0] = mk(K_SYMBOL, 1'b1, r_psc, 1'b0, 64'sd0, r_tsl);
                        n_cnt  = 2'd2;
                        if (is_sym(c)) begin
                            res[1] = mk(K_SYMBOL, 1'b1, c, 1'b0, 64'sd0, r_tsl);
                            n_mode = M_SYMBOL;
                        end else begin
                            res[1] = mk(K_SYMBOL, 1'b0, 8'd0, 1'b1, 64'sd0, r_tsl);
                            start  = 1'b1;
                        end
                    end
                end
                M_NUMBER: begin
                    if (is_digit(c)) begin
                        n_acc = acc_next;
                    end else begin
                        res[0] = mk(K_NUMBER, 1'b0, 8'd0, 1'b1, num_val, r_tsl);
                        n_cnt  = 2'd1;
                        start  = 1'b1;
                    end
                end
                M_SYMBOL: begin
                    n_cnt = 2'd1;
                    if (is_sym(c)) begin
                        res[0] = mk(K_SYMBOL, 1'b1, c, 1'b0, 64'sd0, r_tsl);
                    end else begin
                        res[0] = mk(K_SYMBOL, 1'b0, 8'd0, 1'b1, 64'sd0, r_tsl);
                        start  = 1'b1;
                    end
                end
                M_STRING: begin
                    if (c == C_QUOTE) begin
                        res[0] = mk(K_STRING, 1'b0, 8'd0, 1'b1, 64'sd0, r_tsl);
                        n_cnt  = 2'd1;
                        n_mode = M_IDLE;
                    end else if (c == C_BSLASH) begin
                        n_mode = M_ESCAPE;
                    end else begin
                        res[0]   = mk(K_STRING, 1'b1, c, 1'b0, 64'sd0, r_tsl);
                        n_cnt    = 2'd1;
                        line_inc = (c == C_LF);
                    end
                end
                M_ESCAPE: begin
                    res[0]   = mk(K_STRING, 1'b1, unescape(c), 1'b0, 64'sd0, r_tsl);
                    n_cnt    = 2'd1;
                    line_inc = (c == C_LF);
                    n_mode   = M_STRING;
                end
                default: begin
                    start = 1'b1;
                end
            endcase
        end

        if (start) begin
            n_tsl    = r_line;
            n_mode   = st_mode;
            n_acc    = st_acc;
            n_neg    = st_neg;
            n_psc    = st_psc;
            line_inc = st_inc;
            if (st_put) begin
                res[n_cnt] = st_res;
                n_cnt      = n_cnt + 2'd1;
            end
        end

        if (n_cnt != 2'd0) begin
            res[n_cnt - 2'd1].last = 1'b1;
        end
    end

    assign n_line = (line_inc && r_line != LINE_MAX) ? r_line + 32'd1 : r_line;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_acc  <= 64'd0;
            r_neg  <= 1'b0;
            r_psc  <= 8'd0;
            r_line <= 32'd1;
            r_tsl  <= 32'd1;
            r_cnt  <= 2'd0;
        end else if (in_beat) begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_neg  <= n_neg;
            r_psc  <= n_psc;
            r_line <= n_line;
            r_tsl  <= n_tsl;
            r_cnt  <= n_cnt;
        end else if (out_beat) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_buf <= res;
        end else if (out_beat) begin
            r_buf[0] <= r_buf[1];
            r_buf[1] <= r_buf[2];
        end
    end

endmodule
`default_nettype wire
